@@ sv/mrc_pkg.sv @@
// ----------------------------------------------------------------------------
// mrc_pkg
// Shared types and constants for the mouse report coalescer.
// ----------------------------------------------------------------------------
package mrc_pkg;

  // Default width of the x and y motion accumulators
  localparam int AccWidthDefault = 16;

  // Largest step carried by one report on any axis
  localparam int StepLimit = 127;

  // Item modes
  localparam logic ModeMotion = 1'b0;
  localparam logic ModePoll   = 1'b1;

  // One input transaction as held in the input register
  typedef struct packed {
    logic              mode;
    logic              bus_ready;
    logic              endpoint_ready;
    logic [7:0]        buttons;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [7:0]  delta_wheel;
    logic signed [7:0]  delta_pan;
  } in_item_t;

  // One outgoing report
  typedef struct packed {
    logic [7:0]        buttons;
    logic signed [7:0] x;
    logic signed [7:0] y;
    logic signed [7:0] wheel;
    logic signed [7:0] pan;
  } report_t;

  // Per-axis control from the decision logic
  typedef struct packed {
    logic update;  // item consumed with bus ready: accumulator may change
    logic add;     // motion item: add the delta
    logic send;    // report goes out: subtract the step
  } axis_ctl_t;

endpackage

@@ sv/mrc_in_reg.sv @@
// ----------------------------------------------------------------------------
// mrc_in_reg
// Input register: captures one transaction and holds it until consumed.
// ----------------------------------------------------------------------------
module mrc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  mrc_pkg::in_item_t in_item,
  input  logic              take,
  output logic              item_valid,
  output mrc_pkg::in_item_t item
);

  // Free when empty or when the held item leaves this cycle
  assign in_ready = !item_valid || take;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item <= in_item;
    end
  end

endmodule

@@ sv/mrc_axis.sv @@
// ----------------------------------------------------------------------------
// mrc_axis
// One motion accumulator: saturating add, step clamp and subtract on send.
// ----------------------------------------------------------------------------
module mrc_axis #(
  parameter int ACC_W   = 16,
  parameter int DELTA_W = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  mrc_pkg::axis_ctl_t        ctl,
  input  logic signed [DELTA_W-1:0] delta,
  output logic                      nonzero,
  output logic signed [7:0]         step
);

  localparam int SUM_W = ((ACC_W > DELTA_W) ? ACC_W : DELTA_W) + 1;

  localparam logic signed [SUM_W-1:0] ACC_MAX =
    {{(SUM_W - ACC_W + 1){1'b0}}, {(ACC_W - 1){1'b1}}};
  localparam logic signed [SUM_W-1:0] ACC_MIN =
    {{(SUM_W - ACC_W + 1){1'b1}}, {(ACC_W - 1){1'b0}}};
  localparam logic signed [ACC_W-1:0] LIM_HI = ACC_W'(mrc_pkg::StepLimit);
  localparam logic signed [ACC_W-1:0] LIM_LO = -LIM_HI;

  logic signed [ACC_W-1:0] pending;
  logic signed [ACC_W-1:0] pending_next;
  logic signed [SUM_W-1:0] raw_sum;
  logic signed [ACC_W-1:0] sat_sum;
  logic signed [ACC_W-1:0] cur;

  // Saturating add of the delta
  always_comb begin
    raw_sum = SUM_W'(pending) + SUM_W'(delta);
    if (raw_sum > ACC_MAX) begin
      sat_sum = ACC_MAX[ACC_W-1:0];
    end else if (raw_sum < ACC_MIN) begin
      sat_sum = ACC_MIN[ACC_W-1:0];
    end else begin
      sat_sum = raw_sum[ACC_W-1:0];
    end
    cur = ctl.add ? sat_sum : pending;
  end

  assign nonzero = (cur != '0);

  // Clamp to one report step
  always_comb begin
    if (cur > LIM_HI) begin
      step = LIM_HI[7:0];
    end else if (cur < LIM_LO) begin
      step = LIM_LO[7:0];
    end else begin
      step = cur[7:0];
    end
  end

  // Remove what was sent
  assign pending_next = ctl.send ? (cur - ACC_W'(step)) : cur;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
    end else if (ctl.update) begin
      pending <= pending_next;
    end
  end

endmodule

@@ sv/mrc_out_reg.sv @@
// ----------------------------------------------------------------------------
// mrc_out_reg
// Result register: holds one report until the receiver takes it.
// ----------------------------------------------------------------------------
module mrc_out_reg (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  mrc_pkg::report_t load_report,
  output logic             free,
  output logic             out_valid,
  input  logic             out_ready,
  output mrc_pkg::report_t report
);

  // Room for a new report when empty or draining this cycle
  assign free = !out_valid || out_ready;

  // Valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (free) begin
      out_valid <= load;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    if (free && load) begin
      report <= load_report;
    end
  end

endmodule

@@ sv/mouse_report_coalescer_unit.sv @@
// ----------------------------------------------------------------------------
// mouse_report_coalescer_unit
// Sums relative mouse motion and emits clamped HID mouse reports.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) takes motion or poll transactions; the
// output channel (out_valid/out_ready) carries at most one report for each.
// A transaction is captured in an input register, then processed against
// the accumulators, loading the result register when a report goes out.
// out_valid rises from the result register, after the transaction that
// caused the report has passed through the input register.
// Throughput is one transaction per cycle while the result register has
// room; the update of the accumulators and button state sets that figure.
// Motion with bus_ready low is dropped; a report is sent when bus and
// endpoint are ready and buttons changed or any accumulator is nonzero.
// When the receiver stalls the result register holds its report and a
// transaction in the input register waits; in_ready is low in that same
// cycle, so at most one transaction is held. Reset clears all
// accumulators, the latched and sent buttons, and both valid flags.
// ----------------------------------------------------------------------------
module mouse_report_coalescer_unit #(
  parameter int ACC_WIDTH = mrc_pkg::AccWidthDefault
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              mode,
  input  logic              bus_ready,
  input  logic              endpoint_ready,
  input  logic [7:0]        buttons,
  input  logic signed [15:0] delta_x,
  input  logic signed [15:0] delta_y,
  input  logic signed [7:0]  delta_wheel,
  input  logic signed [7:0]  delta_pan,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        report_buttons,
  output logic signed [7:0] report_x,
  output logic signed [7:0] report_y,
  output logic signed [7:0] report_wheel,
  output logic signed [7:0] report_pan
);

  mrc_pkg::in_item_t  in_item;
  mrc_pkg::in_item_t  item;
  mrc_pkg::report_t   rep_next;
  mrc_pkg::report_t   rep;
  mrc_pkg::axis_ctl_t ctl;
  logic               item_valid;
  logic               out_free;
  logic               advance;
  logic               changed;
  logic [3:0]         nz;
  logic [7:0]         latest_buttons;
  logic [7:0]         sent_buttons;
  logic [7:0]         cur_buttons;

  assign in_item = '{mode: mode, bus_ready: bus_ready, endpoint_ready: endpoint_ready,
                     buttons: buttons, delta_x: delta_x, delta_y: delta_y,
                     delta_wheel: delta_wheel, delta_pan: delta_pan};

  mrc_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .take       (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  // Transaction processed when the result register has room
  assign advance = item_valid && out_free;

  // Decision
  always_comb begin
    ctl.update  = advance && item.bus_ready;
    ctl.add     = ctl.update && (item.mode == mrc_pkg::ModeMotion);
    cur_buttons = ctl.add ? item.buttons : latest_buttons;
    changed     = (cur_buttons != sent_buttons) || (nz != '0);
    ctl.send    = ctl.update && item.endpoint_ready && changed;
  end

  // Accumulators
  mrc_axis #(.ACC_W(ACC_WIDTH), .DELTA_W(16)) u_x (
    .clk (clk), .rst (rst), .ctl (ctl), .delta (item.delta_x),
    .nonzero (nz[0]), .step (rep_next.x)
  );
  mrc_axis #(.ACC_W(ACC_WIDTH), .DELTA_W(16)) u_y (
    .clk (clk), .rst (rst), .ctl (ctl), .delta (item.delta_y),
    .nonzero (nz[1]), .step (rep_next.y)
  );
  mrc_axis #(.ACC_W(8), .DELTA_W(8)) u_wheel (
    .clk (clk), .rst (rst), .ctl (ctl), .delta (item.delta_wheel),
    .nonzero (nz[2]), .step (rep_next.wheel)
  );
  mrc_axis #(.ACC_W(8), .DELTA_W(8)) u_pan (
    .clk (clk), .rst (rst), .ctl (ctl), .delta (item.delta_pan),
    .nonzero (nz[3]), .step (rep_next.pan)
  );

  assign rep_next.buttons = cur_buttons;

  // Button state
  always_ff @(posedge clk) begin
    if (rst) begin
      latest_buttons <= '0;
      sent_buttons   <= '0;
    end else begin
      if (ctl.add) begin
        latest_buttons <= item.buttons;
      end
      if (ctl.send) begin
        sent_buttons <= cur_buttons;
      end
    end
  end

  mrc_out_reg u_out (
    .clk         (clk),
    .rst         (rst),
    .load        (ctl.send),
    .load_report (rep_next),
    .free        (out_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .report      (rep)
  );

  assign report_buttons = rep.buttons;
  assign report_x       = rep.x;
  assign report_y       = rep.y;
  assign report_wheel   = rep.wheel;
  assign report_pan     = rep.pan;

endmodule
